### hdl/iba_pkg.sv
// Shared types and constants for the bitmap identifier allocator.
// No dependencies; used by the controller, datapath, top level and checker.
package iba_pkg;

  localparam int ID_W       = 17;
  localparam int BASE_W     = 16;
  localparam int LIMIT_W    = 14;
  localparam int STATUS_W   = 2;
  localparam int CFG_DATA_W = 16;

  // action codes
  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOCATED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL         = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd3;

  // configuration register indexes
  localparam logic CFG_ID_BASE  = 1'b0;
  localparam logic CFG_ID_LIMIT = 1'b1;

  localparam logic [BASE_W-1:0]  ID_BASE_RESET  = 16'd300;
  localparam logic [LIMIT_W-1:0] ID_LIMIT_RESET = 14'd4701;

  // controller to datapath
  typedef struct packed {
    logic start;      // latch item, rewind scan pointers
    logic clr_step;   // clear one map word
    logic scan_step;  // read next map word, move check stage along
    logic alloc_wr;   // set found bit, capture grant
    logic pend_full;  // capture pool full result
    logic rel_init;   // load slot offset for release walk
    logic pend_oor;   // capture out of range result
    logic walk_step;  // read the map word that holds the release slot
    logic rel_wr;     // clear release bit, capture result
    logic load_out;   // move pending result to output register
  } iba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic act;
    logic clr_last;
    logic hit;
    logic exhausted;
    logic in_range;
    logic located;
    logic slot_free;
  } iba_sts_t;

endpackage

### hdl/iba_ctrl.sv
// Sequencing state machine for the bitmap identifier allocator.
// Depends on iba_pkg for the command and status structs.
module iba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  iba_pkg::iba_sts_t  sts,
  output iba_pkg::iba_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_ALLOC_WR,
    S_REL_WALK,
    S_REL_WR,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.act == iba_pkg::ACT_ALLOC) begin
          state_next = S_SCAN;
        end else if (sts.in_range) begin
          cmd.rel_init = 1'b1;
          state_next   = S_REL_WALK;
        end else begin
          cmd.pend_oor = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_SCAN: begin
        // the check stage holds still once it has an answer
        if (sts.hit) begin
          state_next = S_ALLOC_WR;
        end else if (sts.exhausted) begin
          cmd.pend_full = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_ALLOC_WR: begin
        cmd.alloc_wr = 1'b1;
        state_next   = S_DONE;
      end
      S_REL_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.located) state_next = S_REL_WR;
      end
      S_REL_WR: begin
        cmd.rel_wr = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

### hdl/iba_datapath.sv
// Bitmap memory, configuration registers, scan and release datapath, output register.
// Depends on iba_pkg; driven by iba_ctrl through iba_cmd_t.
module iba_datapath #(
  parameter int POOL_SIZE     = 8192,
  parameter int MAP_WORD_BITS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  iba_pkg::iba_cmd_t                    cmd,
  output iba_pkg::iba_sts_t                    sts,
  input  logic                                 action,
  input  logic [iba_pkg::ID_W-1:0]             release_id,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [iba_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [iba_pkg::ID_W-1:0]             granted_id,
  output logic [iba_pkg::STATUS_W-1:0]         status
);

  localparam int MAP_WORDS = (POOL_SIZE + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int PTR_W     = $clog2(MAP_WORDS + 1);
  localparam int LIM_W     = $clog2(POOL_SIZE + 1);
  localparam int SBASE_W   = $clog2(MAP_WORDS * MAP_WORD_BITS + 1);
  localparam int BIT_W     = $clog2(MAP_WORD_BITS);

  logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];

  logic [iba_pkg::BASE_W-1:0]   id_base;
  logic [iba_pkg::LIMIT_W-1:0]  id_limit;
  logic                         act;
  logic [iba_pkg::ID_W-1:0]     rid;
  logic [PTR_W-1:0]             rd_ptr;
  logic [SBASE_W-1:0]           rd_base;
  logic [PTR_W-1:0]             chk_ptr;
  logic [SBASE_W-1:0]           chk_base;
  logic                         chk_live;
  logic [LIM_W-1:0]             rem;
  logic [MAP_WORD_BITS-1:0]     rdata;
  logic [iba_pkg::ID_W-1:0]     pend_granted;
  logic [iba_pkg::STATUS_W-1:0] pend_status;

  logic [LIM_W-1:0]         eff_lim;
  logic                     exhaust;
  logic [31:0]              span;
  logic [MAP_WORD_BITS-1:0] free_bits;
  logic [MAP_WORD_BITS-1:0] free_low;
  logic [BIT_W-1:0]         hit_bit;
  logic                     ptr_in;
  logic                     located;
  logic [iba_pkg::ID_W:0]   diff;
  logic                     in_range;
  logic [iba_pkg::ID_W-1:0] grant_sum;
  logic [MAP_WORD_BITS-1:0] rel_bit;

  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [MAP_WORD_BITS-1:0] mem_wdata;
  logic                     mem_re;
  logic [ADDR_W-1:0]        mem_raddr;

  assign cfg_ready = 1'b1;

  // a limit beyond the pool acts as the pool size
  assign eff_lim = (32'(id_limit) > 32'(POOL_SIZE)) ? LIM_W'(POOL_SIZE) : LIM_W'(id_limit);

  assign exhaust = 32'(chk_base) >= 32'(eff_lim);
  assign span    = 32'(eff_lim) - 32'(chk_base);

  always_comb begin
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      free_bits[b] = !rdata[b] && (32'(b) < span);
    end
  end

  // isolate lowest free bit, then encode it
  assign free_low = free_bits & (~free_bits + MAP_WORD_BITS'(1));

  always_comb begin
    hit_bit = '0;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      hit_bit = hit_bit | (free_low[b] ? BIT_W'(b) : BIT_W'(0));
    end
  end

  assign ptr_in    = 32'(rd_ptr) < 32'(MAP_WORDS);
  assign located   = 32'(rem) < 32'(MAP_WORD_BITS);
  assign diff      = (iba_pkg::ID_W + 1)'(rid) - (iba_pkg::ID_W + 1)'(id_base);
  assign in_range  = (rid >= iba_pkg::ID_W'(id_base)) && (32'(diff) < 32'(eff_lim));
  assign grant_sum = iba_pkg::ID_W'(32'(id_base) + 32'(chk_base) + 32'(hit_bit));
  assign rel_bit   = MAP_WORD_BITS'(1) << rem[BIT_W-1:0];

  assign sts.act       = act;
  assign sts.clr_last  = (rd_ptr == PTR_W'(MAP_WORDS - 1));
  assign sts.hit       = chk_live && !exhaust && (|free_bits);
  assign sts.exhausted = chk_live && exhaust;
  assign sts.in_range  = in_range;
  assign sts.located   = located;
  assign sts.slot_free = !out_valid || !out_stall;

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = chk_ptr[ADDR_W-1:0];
    mem_wdata = '0;
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = rd_ptr[ADDR_W-1:0];
    end else if (cmd.alloc_wr) begin
      mem_we    = 1'b1;
      mem_wdata = rdata | free_low;
    end else if (cmd.rel_wr) begin
      mem_we    = 1'b1;
      mem_wdata = rdata & ~rel_bit;
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = rd_ptr[ADDR_W-1:0];
    if (cmd.scan_step && ptr_in) begin
      mem_re = 1'b1;
    end else if (cmd.walk_step && located) begin
      mem_re    = 1'b1;
      mem_raddr = chk_ptr[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rdata <= map_mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      id_base   <= iba_pkg::ID_BASE_RESET;
      id_limit  <= iba_pkg::ID_LIMIT_RESET;
      rd_ptr    <= '0;
      chk_live  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          iba_pkg::CFG_ID_BASE:  id_base  <= cfg_data[iba_pkg::BASE_W-1:0];
          iba_pkg::CFG_ID_LIMIT: id_limit <= cfg_data[iba_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        rd_ptr   <= '0;
        chk_live <= 1'b0;
      end else if (cmd.clr_step) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end else if (cmd.scan_step) begin
        chk_live <= 1'b1;
        if (ptr_in) rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and scan position
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act     <= action;
      rid     <= release_id;
      rd_base <= '0;
    end
    if (cmd.scan_step) begin
      chk_ptr  <= rd_ptr;
      chk_base <= rd_base;
      if (ptr_in) rd_base <= rd_base + SBASE_W'(MAP_WORD_BITS);
    end
    if (cmd.rel_init) begin
      // word address is the slot shifted down, bit offset its low bits
      rem     <= LIM_W'(diff[BIT_W-1:0]);
      chk_ptr <= PTR_W'(diff >> BIT_W);
    end
    if (cmd.alloc_wr) begin
      pend_granted <= grant_sum;
      pend_status  <= iba_pkg::ST_ALLOCATED;
    end
    if (cmd.pend_full) begin
      pend_granted <= '0;
      pend_status  <= iba_pkg::ST_FULL;
    end
    if (cmd.pend_oor) begin
      pend_granted <= '0;
      pend_status  <= iba_pkg::ST_OUT_OF_RANGE;
    end
    if (cmd.rel_wr) begin
      pend_granted <= '0;
      pend_status  <= iba_pkg::ST_RELEASED;
    end
    if (cmd.load_out) begin
      granted_id <= pend_granted;
      status     <= pend_status;
    end
  end

endmodule

### hdl/id_bitmap_allocator_unit.sv
// Bitmap identifier allocator, lowest free slot first. An allocate item scans the
// used-slot bitmap one map word per cycle from slot zero; the single bitmap
// memory read port, reading one word a cycle, sets this rate. A release item finds
// its word address as the slot shifted down, and one outside id_base .. id_base+limit-1
// (limit clamped to POOL_SIZE) answers out of range. One item is worked on at a time;
// a finished result waits in the output register while the next item is taken.
// After reset a clearing pass zeroes every map word, with in_stall high;
// configuration writes are taken at all times.
// Depends on iba_pkg, iba_ctrl and iba_datapath.
module id_bitmap_allocator_unit #(
  parameter int POOL_SIZE     = 8192,
  parameter int MAP_WORD_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic [iba_pkg::ID_W-1:0]       release_id,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [iba_pkg::ID_W-1:0]       granted_id,
  output logic [iba_pkg::STATUS_W-1:0]   status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [iba_pkg::CFG_DATA_W-1:0] cfg_data
);

  iba_pkg::iba_cmd_t cmd;
  iba_pkg::iba_sts_t sts;

  iba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  iba_datapath #(
    .POOL_SIZE     (POOL_SIZE),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .action     (action),
    .release_id (release_id),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .granted_id (granted_id),
    .status     (status)
  );

endmodule

### hdl/iba_checker.sv
// Port-level assertions for id_bitmap_allocator_unit, attached by bind.
// Depends on iba_pkg for field widths and status codes.
module iba_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           action,
  input logic [iba_pkg::ID_W-1:0]       release_id,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [iba_pkg::ID_W-1:0]       granted_id,
  input logic [iba_pkg::STATUS_W-1:0]   status,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic                           cfg_index,
  input logic [iba_pkg::CFG_DATA_W-1:0] cfg_data
);

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken straight after reset");

  // one item in flight: an accepted item blocks the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(granted_id) && $stable(status))
    else $error("stalled result changed");

  a_zero_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != iba_pkg::ST_ALLOCATED) |-> granted_id == '0)
    else $error("non-zero id without a grant");

endmodule

bind id_bitmap_allocator_unit iba_checker u_iba_checker (.*);

### tb/testbench.sv
// Self-checking testbench for id_bitmap_allocator_unit: directed and random
// allocate/release items checked against an in-bench bitmap predictor.
// Depends on iba_pkg and the allocator RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_SIZE = 8192;
  localparam int ITEM_TARGET = 850;

  typedef struct packed {
    logic                     act;
    logic [iba_pkg::ID_W-1:0] rid;
  } id_req_t;

  typedef struct packed {
    logic [iba_pkg::ID_W-1:0]     gid;
    logic [iba_pkg::STATUS_W-1:0] st;
  } id_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           action = iba_pkg::ACT_ALLOC;
  logic [iba_pkg::ID_W-1:0]       release_id = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [iba_pkg::ID_W-1:0]       granted_id;
  logic [iba_pkg::STATUS_W-1:0]   status;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic                           cfg_index = iba_pkg::CFG_ID_BASE;
  logic [iba_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state: one used bit per slot plus the live register copies
  bit                          slot_used [POOL_SIZE];
  logic [iba_pkg::BASE_W-1:0]  cur_base  = iba_pkg::ID_BASE_RESET;
  logic [iba_pkg::LIMIT_W-1:0] cur_limit = iba_pkg::ID_LIMIT_RESET;

  id_req_t    pending_reqs [$];
  id_result_t awaited_results [$];
  id_req_t    drv_req;
  id_req_t    mon_req;
  id_result_t seen_exp;

  int  n_queued = 0;
  int  n_accepted = 0;
  int  n_writes = 0;
  int  n_granted = 0;
  int  n_full = 0;
  int  n_released = 0;
  int  n_out_of_range = 0;
  int  errors = 0;
  bit  calm = 1'b0;

  id_bitmap_allocator_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .release_id (release_id),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .granted_id (granted_id),
    .status     (status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int live_slots();
    return (int'(cur_limit) > POOL_SIZE) ? POOL_SIZE : int'(cur_limit);
  endfunction

  // lowest free slot below the limit, or a range-checked release
  function automatic id_result_t allocate_or_release(input id_req_t r);
    id_result_t res;
    int lim;
    int rel;
    lim = live_slots();
    res.gid = '0;
    res.st  = iba_pkg::ST_FULL;
    if (r.act == iba_pkg::ACT_ALLOC) begin
      for (int s = 0; s < lim; s++) begin
        if (!slot_used[s]) begin
          slot_used[s] = 1'b1;
          res.gid = iba_pkg::ID_W'(int'(cur_base) + s);
          res.st  = iba_pkg::ST_ALLOCATED;
          return res;
        end
      end
    end else begin
      rel = int'(r.rid) - int'(cur_base);
      if (rel >= 0 && rel < lim) begin
        slot_used[rel] = 1'b0;
        res.st = iba_pkg::ST_RELEASED;
      end else begin
        res.st = iba_pkg::ST_OUT_OF_RANGE;
      end
    end
    return res;
  endfunction

  task automatic queue_item(input logic act, input logic [iba_pkg::ID_W-1:0] rid);
    id_req_t r;
    r.act = act;
    r.rid = rid;
    pending_reqs.push_back(r);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [iba_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == iba_pkg::CFG_ID_BASE) cur_base = data[iba_pkg::BASE_W-1:0];
    else cur_limit = data[iba_pkg::LIMIT_W-1:0];
    n_writes++;
  endtask

  // driver: next item only once the current one has gone
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
        drv_req = pending_reqs.pop_front();
        in_valid   <= 1'b1;
        action     <= drv_req.act;
        release_id <= drv_req.rid;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(0, 99) < 8);
  end

  // monitor: predict on input accept, then check the result taken this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        mon_req.act = action;
        mon_req.rid = release_id;
        seen_exp = allocate_or_release(mon_req);
        awaited_results.push_back(seen_exp);
        n_accepted++;
        case (seen_exp.st)
          iba_pkg::ST_ALLOCATED: n_granted++;
          iba_pkg::ST_FULL:      n_full++;
          iba_pkg::ST_RELEASED:  n_released++;
          default:               n_out_of_range++;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: granted_id %0d status %0d", granted_id, status);
          errors++;
        end else begin
          seen_exp = awaited_results.pop_front();
          if (granted_id !== seen_exp.gid) begin
            $error("granted_id: expected %0d, got %0d", seen_exp.gid, granted_id);
            errors++;
          end
          if (status !== seen_exp.st) begin
            $error("status: expected %0d, got %0d", seen_exp.st, status);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int ph;
    int lim;
    int span;
    int allocs;
    int n_items;
    int pick;
    logic [iba_pkg::BASE_W-1:0]     new_base;
    logic [iba_pkg::CFG_DATA_W-1:0] lim_data;
    logic [iba_pkg::ID_W-1:0]       rid;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: base 300, 4701 slots
    queue_item(iba_pkg::ACT_ALLOC, '0);
    queue_item(iba_pkg::ACT_ALLOC, '1);
    queue_item(iba_pkg::ACT_RELEASE, iba_pkg::ID_W'(300));
    queue_item(iba_pkg::ACT_ALLOC, '0);
    queue_item(iba_pkg::ACT_RELEASE, iba_pkg::ID_W'(299));
    queue_item(iba_pkg::ACT_RELEASE, iba_pkg::ID_W'(5000));   // last slot, never used
    queue_item(iba_pkg::ACT_RELEASE, iba_pkg::ID_W'(5001));
    queue_item(iba_pkg::ACT_RELEASE, '0);
    queue_item(iba_pkg::ACT_RELEASE, iba_pkg::ID_W'(73727));
    wait_drained();

    // single slot pool at base zero, slot zero already taken
    write_reg(iba_pkg::CFG_ID_BASE, '0);
    write_reg(iba_pkg::CFG_ID_LIMIT, iba_pkg::CFG_DATA_W'(1));
    queue_item(iba_pkg::ACT_ALLOC, '0);
    queue_item(iba_pkg::ACT_RELEASE, '0);
    queue_item(iba_pkg::ACT_ALLOC, '0);
    queue_item(iba_pkg::ACT_ALLOC, '0);
    queue_item(iba_pkg::ACT_RELEASE, iba_pkg::ID_W'(1));
    wait_drained();

    // top base, limit above the pool clamps to the pool size
    write_reg(iba_pkg::CFG_ID_BASE, '1);
    write_reg(iba_pkg::CFG_ID_LIMIT, '1);
    queue_item(iba_pkg::ACT_RELEASE, iba_pkg::ID_W'(73726));
    queue_item(iba_pkg::ACT_RELEASE, iba_pkg::ID_W'(73727));
    queue_item(iba_pkg::ACT_ALLOC, '0);
    queue_item(iba_pkg::ACT_RELEASE, iba_pkg::ID_W'(65534));
    wait_drained();

    // limit zero, written with the upper data bits set
    write_reg(iba_pkg::CFG_ID_LIMIT, iba_pkg::CFG_DATA_W'(16'hC000));
    queue_item(iba_pkg::ACT_ALLOC, '0);
    queue_item(iba_pkg::ACT_RELEASE, iba_pkg::ID_W'(65535));
    wait_drained();

    write_reg(iba_pkg::CFG_ID_BASE, '0);
    write_reg(iba_pkg::CFG_ID_LIMIT, iba_pkg::CFG_DATA_W'(POOL_SIZE));
    queue_item(iba_pkg::ACT_RELEASE, iba_pkg::ID_W'(POOL_SIZE - 1));
    queue_item(iba_pkg::ACT_RELEASE, iba_pkg::ID_W'(POOL_SIZE));
    wait_drained();

    ph = 0;
    while (n_queued < ITEM_TARGET) begin
      pick = $urandom_range(0, 7);
      new_base = (pick == 0) ? '0 : (pick == 1) ? '1 :
                 iba_pkg::BASE_W'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 60) lim_data = iba_pkg::CFG_DATA_W'($urandom_range(1, 150));
      else if (pick < 75)
        lim_data = iba_pkg::CFG_DATA_W'(63 + $urandom_range(0, 2) +
                                        64 * $urandom_range(0, 1));
      else if (pick < 85)
        lim_data = iba_pkg::CFG_DATA_W'($urandom_range(1000, POOL_SIZE));
      else if (pick < 90) lim_data = '0;
      else lim_data = iba_pkg::CFG_DATA_W'($urandom_range(POOL_SIZE + 1, 16383));
      lim_data[iba_pkg::CFG_DATA_W-1:iba_pkg::LIMIT_W] =
        (iba_pkg::CFG_DATA_W - iba_pkg::LIMIT_W)'($urandom_range(0, 3));
      write_reg(iba_pkg::CFG_ID_BASE, new_base);
      write_reg(iba_pkg::CFG_ID_LIMIT, lim_data);
      calm = (ph == 3);
      lim = live_slots();
      allocs = 0;
      n_items = $urandom_range(30, 90);
      repeat (n_items) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          queue_item(iba_pkg::ACT_ALLOC, iba_pkg::ID_W'($urandom_range(0, 73727)));
          allocs++;
        end else if (pick < 90) begin
          // release something the allocations above are likely to hold
          span = (lim < allocs + 4) ? lim : allocs + 4;
          rid = (span == 0) ? iba_pkg::ID_W'(new_base) :
                iba_pkg::ID_W'(int'(new_base) + $urandom_range(0, span - 1));
          queue_item(iba_pkg::ACT_RELEASE, rid);
        end else begin
          case ($urandom_range(0, 3))
            0: rid = iba_pkg::ID_W'($urandom_range(0, 73727));
            1: rid = (new_base == 0) ? '0 : iba_pkg::ID_W'(int'(new_base) - 1);
            2: rid = iba_pkg::ID_W'(int'(new_base) + lim);
            default: rid = iba_pkg::ID_W'(int'(new_base) + ((lim == 0) ? 0 : lim - 1));
          endcase
          queue_item(iba_pkg::ACT_RELEASE, rid);
        end
      end
      wait_drained();
      ph++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (200) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      errors++;
    end
    $display("Ran %0d items across %0d register writes and %0d random settings.",
             n_accepted, n_writes, ph);
    $display("Results: %0d granted, %0d pool full, %0d released, %0d out of range.",
             n_granted, n_full, n_released, n_out_of_range);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
hdl/iba_pkg.sv
hdl/iba_ctrl.sv
hdl/iba_datapath.sv
hdl/id_bitmap_allocator_unit.sv
hdl/iba_checker.sv
tb/testbench.sv
